@@ rtl/dpwm_pkg.sv @@
// dpwm_pkg: shared types, register codes, CORDIC constants and pipeline depths
// for the dual plane-wave moire generator. No dependencies.
package dpwm_pkg;

    // field update modes
    typedef enum logic [1:0] {
        MODE_WAVEVEC = 2'd0,
        MODE_SEP_ADD = 2'd1,
        MODE_SEP_MUL = 2'd2,
        MODE_PROJ    = 2'd3
    } mode_t;

    // register indexes on the APB port (byte address is 4 times the index)
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_WAVE_A_X  = 3'd1,
        REG_WAVE_A_Y  = 3'd2,
        REG_WAVE_B_X  = 3'd3,
        REG_WAVE_B_Y  = 3'd4,
        REG_GAIN_REAL = 3'd5,
        REG_GAIN_IMAG = 3'd6
    } reg_idx_t;

    // operands that ride alongside the phase and trig pipelines
    typedef struct packed {
        logic [31:0]        step;
        logic signed [31:0] acc_re;
        logic signed [31:0] acc_im;
    } side_t;

    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // pipeline depths: phase unit, CORDIC unit, output mixer
    localparam int PH_LAT  = 2;
    localparam int CD_LAT  = CORDIC_STEPS + 2;
    localparam int MIX_LAT = 7;

    // arctangent of 2^-i in 32-bit turns
    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051D;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2E;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            24: r = 32'h00000028;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000002;
            29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/dual_plane_wave_moire_generator_core.sv @@
// dual_plane_wave_moire_generator_core: top level, APB registers, phase
// former, four CORDIC lanes and output mixer. Depends on dpwm_pkg and all dpwm_ modules.
//
// Usage:
//   Command channel: drive the grid point fields with start high; the point
//   is taken at any clock edge where start is high and busy is low. busy
//   stays low, so one point can enter every cycle.
//   Result channel: done is high for one cycle with sum_real and sum_imag;
//   the receiver must take it in that cycle, it cannot stall the block.
//   A point passes from the accepting edge through the phase multipliers,
//   the CORDIC pipeline (30 micro-rotations plus fold and rounding) and
//   the mixer to the edge that takes the result.
//   Throughput is one point per cycle, set by the fully pipelined CORDIC.
//   Registers must be written over APB only while no point is in flight; the
//   block does not enforce this. Reset clears all valid bits and loads register
//   defaults (unit wavenumbers along x, zero gain, wavevector mode).
module dual_plane_wave_moire_generator_core #(
    parameter int PHASE_BITS = 32,
    parameter int TRIG_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_u,
    input  logic [31:0]        offset_first,
    input  logic [31:0]        offset_second,
    input  logic [31:0]        step_scale,
    input  logic signed [31:0] acc_real,
    input  logic signed [31:0] acc_imag,
    output logic               done,
    output logic signed [31:0] sum_real,
    output logic signed [31:0] sum_imag,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import dpwm_pkg::*;

    localparam int PRE_LAT = PH_LAT + CD_LAT;
    localparam int LAT     = PRE_LAT + MIX_LAT;

    mode_t              mode_reg;
    logic signed [31:0] wave_a_x_reg, wave_a_y_reg, wave_b_x_reg, wave_b_y_reg;
    logic signed [23:0] gain_real_reg, gain_imag_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic               accept;

    logic [PRE_LAT-1:0] vld_reg;
    side_t              side_reg [0:PRE_LAT-1];

    logic [PHASE_BITS-1:0] ph_a0, ph_b0, ph_a1, ph_b1;
    logic signed [TRIG_BITS-1:0] ca0, sa0, cb0, sb0, ca1, sa1, cb1, sb1;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    // register file writes
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAVEVEC;
            wave_a_x_reg  <= 32'sd16777216;
            wave_a_y_reg  <= '0;
            wave_b_x_reg  <= 32'sd16777216;
            wave_b_y_reg  <= '0;
            gain_real_reg <= '0;
            gain_imag_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MODE:      mode_reg      <= mode_t'(pwdata[1:0]);
                REG_WAVE_A_X:  wave_a_x_reg  <= pwdata;
                REG_WAVE_A_Y:  wave_a_y_reg  <= pwdata;
                REG_WAVE_B_X:  wave_b_x_reg  <= pwdata;
                REG_WAVE_B_Y:  wave_b_y_reg  <= pwdata;
                REG_GAIN_REAL: gain_real_reg <= pwdata[23:0];
                REG_GAIN_IMAG: gain_imag_reg <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_MODE:      prdata = {30'd0, mode_reg};
            REG_WAVE_A_X:  prdata = wave_a_x_reg;
            REG_WAVE_A_Y:  prdata = wave_a_y_reg;
            REG_WAVE_B_X:  prdata = wave_b_x_reg;
            REG_WAVE_B_Y:  prdata = wave_b_y_reg;
            REG_GAIN_REAL: prdata = {8'd0, gain_real_reg};
            REG_GAIN_IMAG: prdata = {8'd0, gain_imag_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // valid bits and side operands alongside phase and trig pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PRE_LAT-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{step: step_scale, acc_re: acc_real, acc_im: acc_imag};
        for (int k = 1; k < PRE_LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // phase former
    dpwm_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk           (clk),
        .mode          (mode_reg),
        .wave_a_x      (wave_a_x_reg),
        .wave_a_y      (wave_a_y_reg),
        .wave_b_x      (wave_b_x_reg),
        .wave_b_y      (wave_b_y_reg),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_u       (coord_u),
        .offset_first  (offset_first),
        .offset_second (offset_second),
        .phase_a0      (ph_a0),
        .phase_b0      (ph_b0),
        .phase_a1      (ph_a1),
        .phase_b1      (ph_b1)
    );

    // four sine/cosine lanes
    dpwm_cordic #(.PHASE_BITS(PHASE_BITS), .TRIG_BITS(TRIG_BITS)) u_cordic_a0 (
        .clk (clk), .phase (ph_a0), .cos_val (ca0), .sin_val (sa0)
    );
    dpwm_cordic #(.PHASE_BITS(PHASE_BITS), .TRIG_BITS(TRIG_BITS)) u_cordic_b0 (
        .clk (clk), .phase (ph_b0), .cos_val (cb0), .sin_val (sb0)
    );
    dpwm_cordic #(.PHASE_BITS(PHASE_BITS), .TRIG_BITS(TRIG_BITS)) u_cordic_a1 (
        .clk (clk), .phase (ph_a1), .cos_val (ca1), .sin_val (sa1)
    );
    dpwm_cordic #(.PHASE_BITS(PHASE_BITS), .TRIG_BITS(TRIG_BITS)) u_cordic_b1 (
        .clk (clk), .phase (ph_b1), .cos_val (cb1), .sin_val (sb1)
    );

    // combine, gain, step and accumulate
    dpwm_mix #(
        .TRIG_BITS (TRIG_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[PRE_LAT-1]),
        .in_side   (side_reg[PRE_LAT-1]),
        .mode      (mode_reg),
        .gain_real (gain_real_reg),
        .gain_imag (gain_imag_reg),
        .ca0       (ca0),
        .sa0       (sa0),
        .cb0       (cb0),
        .sb0       (sb0),
        .ca1       (ca1),
        .sa1       (sa1),
        .cb1       (cb1),
        .sb1       (sb1),
        .out_valid (done),
        .sum_real  (sum_real),
        .sum_imag  (sum_imag)
    );

    // every result traces back to an earlier command transfer
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching command transfer");

    // zero gain leaves the field value untouched
    a_zero_gain_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (done && gain_real_reg == 24'sd0 && gain_imag_reg == 24'sd0) |->
        (sum_real == $past(acc_real, LAT) && sum_imag == $past(acc_imag, LAT)))
        else $error("zero gain changed the field value");

endmodule

@@ rtl/dpwm_phase.sv @@
// dpwm_phase: two-stage phase former, coordinate times wavenumber products
// then turn extraction and offset add. Depends on dpwm_pkg.
module dpwm_phase #(
    parameter int PHASE_BITS = 32
) (
    input  logic                    clk,
    input  dpwm_pkg::mode_t         mode,
    input  logic signed [31:0]      wave_a_x,
    input  logic signed [31:0]      wave_a_y,
    input  logic signed [31:0]      wave_b_x,
    input  logic signed [31:0]      wave_b_y,
    input  logic signed [31:0]      coord_x,
    input  logic signed [31:0]      coord_y,
    input  logic signed [31:0]      coord_u,
    input  logic [31:0]             offset_first,
    input  logic [31:0]             offset_second,
    output logic [PHASE_BITS-1:0]   phase_a0,
    output logic [PHASE_BITS-1:0]   phase_b0,
    output logic [PHASE_BITS-1:0]   phase_a1,
    output logic [PHASE_BITS-1:0]   phase_b1
);
    import dpwm_pkg::*;

    logic signed [31:0] coord0;
    logic               use_y;
    logic signed [63:0] m_ax0, m_ay, m_bx0, m_by, m_ax1, m_bx1;
    logic [39:0]        ax0_reg, ay_reg, bx0_reg, by_reg, ax1_reg, bx1_reg;
    logic [31:0]        off_a_reg, off_b_reg;
    logic [39:0]        dot_a0, dot_b0;
    logic [31:0]        turn_a0, turn_b0, turn_a1, turn_b1;
    logic [PHASE_BITS-1:0] pa0_reg, pb0_reg, pa1_reg, pb1_reg;

    // stage 1: exact products, only the low 40 bits matter
    always_comb
    begin
        coord0 = (mode == MODE_PROJ) ? coord_u : coord_x;
        use_y  = (mode == MODE_WAVEVEC);
        m_ax0  = wave_a_x * coord0;
        m_bx0  = wave_b_x * coord0;
        m_ay   = wave_a_y * coord_y;
        m_by   = wave_b_y * coord_y;
        m_ax1  = wave_a_x * coord_y;
        m_bx1  = wave_b_x * coord_y;
    end

    always_ff @(posedge clk)
    begin
        ax0_reg   <= m_ax0[39:0];
        bx0_reg   <= m_bx0[39:0];
        ay_reg    <= use_y ? m_ay[39:0] : 40'd0;
        by_reg    <= use_y ? m_by[39:0] : 40'd0;
        ax1_reg   <= m_ax1[39:0];
        bx1_reg   <= m_bx1[39:0];
        off_a_reg <= offset_first;
        off_b_reg <= offset_second;
    end

    // stage 2: sum, take turns bits 8..39, add offset, keep the top bits
    always_comb
    begin
        dot_a0  = ax0_reg + ay_reg;
        dot_b0  = bx0_reg + by_reg;
        turn_a0 = dot_a0[39:8] + off_a_reg;
        turn_b0 = dot_b0[39:8] + off_b_reg;
        turn_a1 = ax1_reg[39:8] + off_a_reg;
        turn_b1 = bx1_reg[39:8] + off_b_reg;
    end

    always_ff @(posedge clk)
    begin
        pa0_reg <= turn_a0[31 -: PHASE_BITS];
        pb0_reg <= turn_b0[31 -: PHASE_BITS];
        pa1_reg <= turn_a1[31 -: PHASE_BITS];
        pb1_reg <= turn_b1[31 -: PHASE_BITS];
    end

    assign phase_a0 = pa0_reg;
    assign phase_b0 = pb0_reg;
    assign phase_a1 = pa1_reg;
    assign phase_b1 = pb1_reg;

endmodule

@@ rtl/dpwm_cordic.sv @@
// dpwm_cordic: fully pipelined sine/cosine of a phase in turns, quadrant
// fold, one CORDIC micro-rotation per stage, rounding. Depends on dpwm_pkg.
module dpwm_cordic #(
    parameter int PHASE_BITS = 32,
    parameter int TRIG_BITS  = 16
) (
    input  logic                        clk,
    input  logic [PHASE_BITS-1:0]       phase,
    output logic signed [TRIG_BITS-1:0] cos_val,
    output logic signed [TRIG_BITS-1:0] sin_val
);
    import dpwm_pkg::*;

    localparam int SH = 31 - TRIG_BITS;
    localparam logic signed [CW-1:0] RND = CW'(1) <<< (SH - 1);
    localparam logic signed [CW-1:0] LIM = (CW'(1) <<< (TRIG_BITS - 1)) - CW'(1);

    logic [31:0]          p32, zdiff;
    logic [1:0]           quad;
    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg [0:CORDIC_STEPS];
    logic [1:0]           q_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] cx, cy, rc, rs;
    logic signed [TRIG_BITS-1:0] cos_reg, sin_reg;

    // quadrant fold to the nearest axis
    always_comb
    begin
        p32   = 32'(phase) << (32 - PHASE_BITS);
        quad  = 2'((p32 + 32'h2000_0000) >> 30);
        zdiff = p32 - {quad, 30'd0};
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= CW'($signed(zdiff));
        q_reg[0] <= quad;
    end

    // micro-rotation stages
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] dx, dy, da;
        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            da = $signed({2'b00, atan_turns(i)});
        end
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - da;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + da;
            end
            q_reg[i+1] <= q_reg[i];
        end
    end

    // unfold the quadrant and round to the trig format
    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:    begin cx = x_reg[CORDIC_STEPS];  cy = y_reg[CORDIC_STEPS];  end
            2'd1:    begin cx = -y_reg[CORDIC_STEPS]; cy = x_reg[CORDIC_STEPS];  end
            2'd2:    begin cx = -x_reg[CORDIC_STEPS]; cy = -y_reg[CORDIC_STEPS]; end
            default: begin cx = y_reg[CORDIC_STEPS];  cy = -x_reg[CORDIC_STEPS]; end
        endcase
        rc = (cx + RND) >>> SH;
        rs = (cy + RND) >>> SH;
        if (rc > LIM)
            rc = LIM;
        if (rc < -LIM)
            rc = -LIM;
        if (rs > LIM)
            rs = LIM;
        if (rs < -LIM)
            rs = -LIM;
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= rc[TRIG_BITS-1:0];
        sin_reg <= rs[TRIG_BITS-1:0];
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ rtl/dpwm_mix.sv @@
// dpwm_mix: wave combine by mode, complex gain, step scaling and saturating
// accumulate, seven register stages with valid bits. Depends on dpwm_pkg.
module dpwm_mix #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  dpwm_pkg::side_t             in_side,
    input  dpwm_pkg::mode_t             mode,
    input  logic signed [23:0]          gain_real,
    input  logic signed [23:0]          gain_imag,
    input  logic signed [TRIG_BITS-1:0] ca0,
    input  logic signed [TRIG_BITS-1:0] sa0,
    input  logic signed [TRIG_BITS-1:0] cb0,
    input  logic signed [TRIG_BITS-1:0] sb0,
    input  logic signed [TRIG_BITS-1:0] ca1,
    input  logic signed [TRIG_BITS-1:0] sa1,
    input  logic signed [TRIG_BITS-1:0] cb1,
    input  logic signed [TRIG_BITS-1:0] sb1,
    output logic                        out_valid,
    output logic signed [31:0]          sum_real,
    output logic signed [31:0]          sum_imag
);
    import dpwm_pkg::*;

    localparam int WS = TRIG_BITS + 1;
    localparam int PW = 2 * WS;
    localparam int WW = TRIG_BITS + 3;
    localparam int GW = WW + 24;
    localparam int OW = GW + 1;
    localparam int SH = TRIG_BITS - 8;
    localparam int VW = OW + 1 - SH;
    localparam int AW = VW + 17;
    localparam logic signed [PW+1:0] HALF_W = (PW + 2)'(1) <<< (TRIG_BITS - 1);
    localparam logic signed [OW:0]   RND_O  = (OW + 1)'(1) <<< (SH - 1);
    localparam logic signed [AW:0]   RND_D  = (AW + 1)'(32768);
    localparam logic signed [AW+1:0] SMAX   = (AW + 2)'(64'sd2147483647);
    localparam logic signed [AW+1:0] SMIN   = (AW + 2)'(-64'sd2147483648);

    logic [MIX_LAT-1:0] vld_reg;
    side_t              side_reg [0:MIX_LAT-2];

    logic signed [WS-1:0] rx_reg, ix_reg, ry_reg, iy_reg;
    logic signed [WS-1:0] rx1_reg, ix1_reg, ry1_reg, iy1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW+1:0] num_re, num_im;
    logic signed [WW-1:0] wr_next, wi_next, wr_reg, wi_reg;
    logic signed [GW-1:0] g_rr_reg, g_ii_reg, g_ri_reg, g_ir_reg;
    logic signed [OW:0]   o_re, o_im;
    logic signed [VW-1:0] v_re_reg, v_im_reg;
    logic signed [AW-1:0] a_re_reg, b_re_reg, a_im_reg, b_im_reg;
    logic signed [AW:0]   d_re, d_im;
    logic signed [AW+1:0] s_re, s_im;
    logic signed [31:0]   sum_re_reg, sum_im_reg;

    // valid bits and side operands travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[MIX_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < MIX_LAT - 1; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // stage 0: sum of the two waves for each phase set
    always_ff @(posedge clk)
    begin
        rx_reg <= WS'(ca0) + WS'(cb0);
        ix_reg <= WS'(sa0) + WS'(sb0);
        ry_reg <= WS'(ca1) + WS'(cb1);
        iy_reg <= WS'(sa1) + WS'(sb1);
    end

    // stage 1: cross products for the separable multiply
    always_ff @(posedge clk)
    begin
        p_rr_reg <= rx_reg * ry_reg;
        p_ii_reg <= ix_reg * iy_reg;
        p_ri_reg <= rx_reg * iy_reg;
        p_ir_reg <= ix_reg * ry_reg;
        rx1_reg  <= rx_reg;
        ix1_reg  <= ix_reg;
        ry1_reg  <= ry_reg;
        iy1_reg  <= iy_reg;
    end

    // stage 2: wave value by mode
    always_comb
    begin
        num_re = (PW + 2)'(p_rr_reg) - (PW + 2)'(p_ii_reg) + HALF_W;
        num_im = (PW + 2)'(p_ri_reg) + (PW + 2)'(p_ir_reg) + HALF_W;
        case (mode) inside
            MODE_SEP_ADD:
            begin
                wr_next = WW'(rx1_reg) + WW'(ry1_reg);
                wi_next = WW'(ix1_reg) + WW'(iy1_reg);
            end
            MODE_SEP_MUL:
            begin
                wr_next = WW'(num_re >>> TRIG_BITS);
                wi_next = WW'(num_im >>> TRIG_BITS);
            end
            default:
            begin
                wr_next = WW'(rx1_reg);
                wi_next = WW'(ix1_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        wr_reg <= wr_next;
        wi_reg <= wi_next;
    end

    // stage 3: complex gain products
    always_ff @(posedge clk)
    begin
        g_rr_reg <= wr_reg * gain_real;
        g_ii_reg <= wi_reg * gain_imag;
        g_ri_reg <= wr_reg * gain_imag;
        g_ir_reg <= wi_reg * gain_real;
    end

    // stage 4: combine and round to scale 2^-24
    always_comb
    begin
        o_re = (OW + 1)'(g_rr_reg) - (OW + 1)'(g_ii_reg) + RND_O;
        o_im = (OW + 1)'(g_ri_reg) + (OW + 1)'(g_ir_reg) + RND_O;
    end

    always_ff @(posedge clk)
    begin
        v_re_reg <= VW'(o_re >>> SH);
        v_im_reg <= VW'(o_im >>> SH);
    end

    // stage 5: step scaling as two 16-bit halves
    always_ff @(posedge clk)
    begin
        a_re_reg <= v_re_reg * $signed({1'b0, side_reg[4].step[31:16]});
        b_re_reg <= v_re_reg * $signed({1'b0, side_reg[4].step[15:0]});
        a_im_reg <= v_im_reg * $signed({1'b0, side_reg[4].step[31:16]});
        b_im_reg <= v_im_reg * $signed({1'b0, side_reg[4].step[15:0]});
    end

    // stage 6: round to Q16.16, accumulate, saturate
    always_comb
    begin
        d_re = ((AW + 1)'(a_re_reg) + (AW + 1)'(b_re_reg >>> 16) + RND_D) >>> 16;
        d_im = ((AW + 1)'(a_im_reg) + (AW + 1)'(b_im_reg >>> 16) + RND_D) >>> 16;
        s_re = (AW + 2)'(side_reg[5].acc_re) + (AW + 2)'(d_re);
        s_im = (AW + 2)'(side_reg[5].acc_im) + (AW + 2)'(d_im);
        if (s_re > SMAX)
            s_re = SMAX;
        if (s_re < SMIN)
            s_re = SMIN;
        if (s_im > SMAX)
            s_im = SMAX;
        if (s_im < SMIN)
            s_im = SMIN;
    end

    always_ff @(posedge clk)
    begin
        sum_re_reg <= s_re[31:0];
        sum_im_reg <= s_im[31:0];
    end

    assign out_valid = vld_reg[MIX_LAT-1];
    assign sum_real  = sum_re_reg;
    assign sum_imag  = sum_im_reg;

endmodule
